### hw/rtl/ocp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_pkg: shared types and helpers for the order crossover block
// Gene widths, sequencer states, lane control bundle and the cyclic
// position step used by the top, lane and merge modules.
// ----------------------------------------------------------------------------
package ocp_pkg;

  localparam int MAX_GENES = 64;
  localparam int GENE_W    = $clog2(MAX_GENES);
  localparam int COUNT_W   = GENE_W + 1;

  typedef logic [GENE_W-1:0]  gene_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_RESET = count_t'(MAX_GENES);
  localparam count_t COUNT_MIN   = count_t'(2);
  localparam count_t COUNT_MAX   = count_t'(MAX_GENES);

  // command codes carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // sequencer to lane control
  typedef struct packed {
    logic   start;       // run accepted: clear sets, load fill pointer
    logic   seg_issue;   // parent read for a segment position issued
    logic   scan_issue;  // parent read for a scan position issued
    logic   out_issue;   // child read for an output position issued
    gene_t  seg_pos;     // segment position being read
    gene_t  out_pos;     // output position being read
    gene_t  hi;          // segment end, valid with start
    count_t n;           // gene count of the current run
  } lane_ctrl_t;

  // lane result for one output position
  typedef struct packed {
    gene_t gene;
    logic  vld;          // position was filled during this run
  } lane_out_t;

  // step one position forward, wrapping at the gene count
  function automatic gene_t next_pos(input gene_t p, input count_t n);
    count_t p1;
    p1 = count_t'(p) + count_t'(1);
    next_pos = (p1 >= n) ? gene_t'(0) : p1[GENE_W-1:0];
  endfunction

endpackage

### hw/rtl/order_crossover_permutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_crossover_permutation: order crossover (OX) of two permutations
//
// Slave port: in_tuser selects the command. A load transfer writes one gene
// of each parent at a position. A run transfer gives two cut points; the
// lower starts the segment, the higher ends it, and cuts at or beyond the
// gene count saturate to count-1.
// Master port: a run emits city_count transfers in ascending position, each
// with both child genes; tlast marks the final position.
// cfg_we/cfg_wdata write city_count (clamped to 2..64 when a run starts);
// write only while no run is in progress.
// Run sequence: with n genes and L = hi-lo+1, a run copies the L segment
// positions, then scans n positions (one parent read per cycle, shared by
// the two parallel lanes), passes the drain state, then issues n child
// reads, one per cycle while the output buffer has room. in_tready stays
// low from the run's accepting edge until the sequencer is idle again.
// Loads go one per cycle.
// Reset: city_count returns to 64, sequencer idle, output buffer empty;
// parent genes are undefined until loaded.
// Stall: a two-entry output buffer absorbs tready low; child reads pause
// until space frees, and no result is lost or repeated.
// ----------------------------------------------------------------------------
module order_crossover_permutation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // position, gene_first, gene_second, cut_a, cut_b
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_position, child_first_gene, child_second_gene
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata   // city_count
);

  ocp_pkg::state_t state_r, state_nxt;
  ocp_pkg::count_t city_count_r;
  ocp_pkg::count_t n_r, n_nxt;
  ocp_pkg::gene_t  hi_r, hi_nxt;
  ocp_pkg::gene_t  seg_pos_r, seg_pos_nxt;
  ocp_pkg::gene_t  scan_pos_r, scan_pos_nxt;
  ocp_pkg::count_t step_r, step_nxt;
  ocp_pkg::count_t out_k_r, out_k_nxt;

  logic                accept;
  logic                run_go;
  logic                load_go;
  ocp_pkg::gene_t      f_pos, f_g1, f_g2, f_a, f_b;
  ocp_pkg::count_t     n_c, nm1_c;
  ocp_pkg::gene_t      lo0, hi0, lo_c, hi_c;
  ocp_pkg::gene_t      par_raddr;
  ocp_pkg::gene_t      par_first, par_second;
  ocp_pkg::lane_ctrl_t ctrl;
  ocp_pkg::lane_out_t  res_first, res_second;
  logic                room;
  logic                out_issue;
  logic                out_last;

  // slave port field split
  assign f_pos = in_tdata[5:0];
  assign f_g1  = in_tdata[11:6];
  assign f_g2  = in_tdata[17:12];
  assign f_a   = in_tdata[23:18];
  assign f_b   = in_tdata[29:24];

  assign accept  = in_tvalid && in_tready;
  assign run_go  = accept && (in_tuser == ocp_pkg::CMD_RUN);
  assign load_go = accept && (in_tuser == ocp_pkg::CMD_LOAD);

  // gene count clamp and ordered, saturated cuts
  always_comb begin
    if (city_count_r < ocp_pkg::COUNT_MIN) begin
      n_c = ocp_pkg::COUNT_MIN;
    end else if (city_count_r > ocp_pkg::COUNT_MAX) begin
      n_c = ocp_pkg::COUNT_MAX;
    end else begin
      n_c = city_count_r;
    end
    nm1_c = n_c - ocp_pkg::count_t'(1);
    lo0   = (f_a < f_b) ? f_a : f_b;
    hi0   = (f_a < f_b) ? f_b : f_a;
    hi_c  = (ocp_pkg::count_t'(hi0) > nm1_c) ? nm1_c[ocp_pkg::GENE_W-1:0] : hi0;
    lo_c  = (lo0 > hi_c) ? hi_c : lo0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ocp_pkg::ST_IDLE: begin
        if (run_go) begin
          state_nxt = ocp_pkg::ST_SEG;
        end
      end
      ocp_pkg::ST_SEG: begin
        if (seg_pos_r == hi_r) begin
          state_nxt = ocp_pkg::ST_SCAN;
        end
      end
      ocp_pkg::ST_SCAN: begin
        if (step_r == n_r - ocp_pkg::count_t'(1)) begin
          state_nxt = ocp_pkg::ST_DRAIN;
        end
      end
      ocp_pkg::ST_DRAIN: begin
        state_nxt = ocp_pkg::ST_OUT;
      end
      ocp_pkg::ST_OUT: begin
        if (out_issue && out_last) begin
          state_nxt = ocp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ocp_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    out_issue = 1'b0;
    par_raddr = scan_pos_r;
    case (state_r)
      ocp_pkg::ST_IDLE:  in_tready = 1'b1;
      ocp_pkg::ST_SEG:   par_raddr = seg_pos_r;
      ocp_pkg::ST_SCAN:  par_raddr = scan_pos_r;
      ocp_pkg::ST_DRAIN: par_raddr = scan_pos_r;
      ocp_pkg::ST_OUT:   out_issue = room;
      default:           in_tready = 1'b0;
    endcase
    out_last = (out_k_r == n_r - ocp_pkg::count_t'(1));
  end

  // lane control bundle
  always_comb begin
    ctrl.start      = run_go;
    ctrl.seg_issue  = (state_r == ocp_pkg::ST_SEG);
    ctrl.scan_issue = (state_r == ocp_pkg::ST_SCAN);
    ctrl.out_issue  = out_issue;
    ctrl.seg_pos    = seg_pos_r;
    ctrl.out_pos    = out_k_r[ocp_pkg::GENE_W-1:0];
    ctrl.hi         = hi_c;
    ctrl.n          = n_r;
  end

  // position counters
  always_comb begin
    n_nxt        = n_r;
    hi_nxt       = hi_r;
    seg_pos_nxt  = seg_pos_r;
    scan_pos_nxt = scan_pos_r;
    step_nxt     = step_r;
    out_k_nxt    = out_k_r;
    if (run_go) begin
      n_nxt       = n_c;
      hi_nxt      = hi_c;
      seg_pos_nxt = lo_c;
    end
    if (state_r == ocp_pkg::ST_SEG) begin
      seg_pos_nxt  = seg_pos_r + ocp_pkg::gene_t'(1);
      scan_pos_nxt = ocp_pkg::next_pos(hi_r, n_r);
      step_nxt     = '0;
    end
    if (state_r == ocp_pkg::ST_SCAN) begin
      scan_pos_nxt = ocp_pkg::next_pos(scan_pos_r, n_r);
      step_nxt     = step_r + ocp_pkg::count_t'(1);
    end
    if (state_r == ocp_pkg::ST_DRAIN) begin
      out_k_nxt = '0;
    end
    if (out_issue) begin
      out_k_nxt = out_k_r + ocp_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ocp_pkg::ST_IDLE;
      city_count_r <= ocp_pkg::COUNT_RESET;
      n_r          <= ocp_pkg::COUNT_MAX;
      hi_r         <= '0;
      seg_pos_r    <= '0;
      scan_pos_r   <= '0;
      step_r       <= '0;
      out_k_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      hi_r       <= hi_nxt;
      seg_pos_r  <= seg_pos_nxt;
      scan_pos_r <= scan_pos_nxt;
      step_r     <= step_nxt;
      out_k_r    <= out_k_nxt;
      if (cfg_we) begin
        city_count_r <= cfg_wdata;
      end
    end
  end

  // parent stores, shared by both lanes
  ocp_ram #(
    .WIDTH(ocp_pkg::GENE_W),
    .DEPTH(ocp_pkg::MAX_GENES)
  ) u_parent_first (
    .clk  (clk),
    .we   (load_go),
    .waddr(f_pos),
    .wdata(f_g1),
    .raddr(par_raddr),
    .rdata(par_first)
  );

  ocp_ram #(
    .WIDTH(ocp_pkg::GENE_W),
    .DEPTH(ocp_pkg::MAX_GENES)
  ) u_parent_second (
    .clk  (clk),
    .we   (load_go),
    .waddr(f_pos),
    .wdata(f_g2),
    .raddr(par_raddr),
    .rdata(par_second)
  );

  // first child: second parent's segment, first parent's scan
  ocp_lane u_lane_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .own_gene  (par_first),
    .other_gene(par_second),
    .result    (res_first)
  );

  // second child: first parent's segment, second parent's scan
  ocp_lane u_lane_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .own_gene  (par_second),
    .other_gene(par_first),
    .result    (res_second)
  );

  ocp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (out_issue),
    .pos        (out_k_r[ocp_pkg::GENE_W-1:0]),
    .last       (out_last),
    .lane_first (res_first),
    .lane_second(res_second),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // a run transfer always starts the segment copy
  assert property (@(posedge clk) disable iff (!rst_n)
    run_go |=> (state_r == ocp_pkg::ST_SEG))
    else $error("run did not start segment copy");

  // segment reads stay at or below the segment end
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ocp_pkg::ST_SEG) |-> (seg_pos_r <= hi_r))
    else $error("segment read past its end");

  // scan addresses stay inside the gene count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ocp_pkg::ST_SCAN) |-> (ocp_pkg::count_t'(scan_pos_r) < n_r))
    else $error("scan address beyond gene count");

  // output addresses stay inside the gene count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_issue |-> (out_k_r < n_r))
    else $error("output address beyond gene count");

endmodule

### hw/rtl/ocp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ocp_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ocp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_lane: one child builder
// Copies the other parent's segment, records its genes, then fills the
// remaining positions from its own parent's scan. Holds the child RAM.
// ----------------------------------------------------------------------------
module ocp_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  ocp_pkg::lane_ctrl_t ctrl,
  input  ocp_pkg::gene_t     own_gene,    // own parent, in the cycle after issue
  input  ocp_pkg::gene_t     other_gene,  // other parent, in the cycle after issue
  output ocp_pkg::lane_out_t result
);

  logic                            seg_d_r;
  logic                            scan_d_r;
  ocp_pkg::gene_t                  seg_pos_d_r;
  logic [ocp_pkg::MAX_GENES-1:0]   member_r, member_nxt;
  logic [ocp_pkg::MAX_GENES-1:0]   valid_r, valid_nxt;
  ocp_pkg::gene_t                  fp_r, fp_nxt;
  logic                            vld_rd_r;

  logic           fill_hit;
  ocp_pkg::gene_t fp_step;
  logic           wr_en;
  ocp_pkg::gene_t wr_addr;
  ocp_pkg::gene_t wr_data;
  ocp_pkg::gene_t rd_gene;

  // write side: segment copy or scan fill
  always_comb begin
    fill_hit = scan_d_r && !member_r[own_gene];
    fp_step  = ocp_pkg::next_pos(fp_r, ctrl.n);
    wr_en    = seg_d_r || fill_hit;
    wr_addr  = seg_d_r ? seg_pos_d_r : fp_step;
    wr_data  = seg_d_r ? other_gene : own_gene;
  end

  // gene set, filled positions, fill pointer
  always_comb begin
    member_nxt = member_r;
    valid_nxt  = valid_r;
    fp_nxt     = fp_r;
    if (ctrl.start) begin
      member_nxt = '0;
      valid_nxt  = '0;
      fp_nxt     = ctrl.hi;
    end else begin
      if (seg_d_r) begin
        member_nxt[other_gene] = 1'b1;
      end
      if (wr_en) begin
        valid_nxt[wr_addr] = 1'b1;
      end
      if (fill_hit) begin
        fp_nxt = fp_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_d_r  <= 1'b0;
      scan_d_r <= 1'b0;
      member_r <= '0;
      valid_r  <= '0;
      fp_r     <= '0;
    end else begin
      seg_d_r  <= ctrl.seg_issue;
      scan_d_r <= ctrl.scan_issue;
      member_r <= member_nxt;
      valid_r  <= valid_nxt;
      fp_r     <= fp_nxt;
    end
  end

  // payload alongside the parent read and the child read
  always_ff @(posedge clk) begin
    seg_pos_d_r <= ctrl.seg_pos;
    if (ctrl.out_issue) begin
      vld_rd_r <= valid_r[ctrl.out_pos];
    end
  end

  ocp_ram #(
    .WIDTH(ocp_pkg::GENE_W),
    .DEPTH(ocp_pkg::MAX_GENES)
  ) u_child_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(ctrl.out_pos),
    .rdata(rd_gene)
  );

  assign result.gene = rd_gene;
  assign result.vld  = vld_rd_r;

endmodule

### hw/rtl/ocp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocp_merge: output merge stage
// Joins both lanes' child genes with position and last flag into one
// result and queues it in a two-entry buffer toward the master port.
// ----------------------------------------------------------------------------
module ocp_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,        // child read issued this cycle
  input  ocp_pkg::gene_t     pos,
  input  logic               last,
  input  ocp_pkg::lane_out_t lane_first,
  input  ocp_pkg::lane_out_t lane_second,
  output logic               room,        // a new read may be issued
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,   // out_position, child_first_gene, child_second_gene
  output logic               out_tlast    // last
);

  typedef struct packed {
    logic           last;
    ocp_pkg::gene_t c2;
    ocp_pkg::gene_t c1;
    ocp_pkg::gene_t pos;
  } entry_t;

  logic           push_d_r;
  ocp_pkg::gene_t pos_d_r;
  logic           last_d_r;
  entry_t         buf_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r, count_nxt;

  entry_t     entry;
  logic       pop;
  logic [2:0] occ;

  // merge the lanes; unfilled positions read as zero
  always_comb begin
    entry.pos  = pos_d_r;
    entry.c1   = lane_first.vld ? lane_first.gene : '0;
    entry.c2   = lane_second.vld ? lane_second.gene : '0;
    entry.last = last_d_r;
  end

  // occupancy and credit for the next read
  always_comb begin
    pop       = out_tvalid && out_tready;
    occ       = {1'b0, count_r} + {2'b00, push_d_r};
    count_nxt = 2'(occ - {2'b00, pop});
    room      = (occ - {2'b00, pop}) < 3'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_d_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      push_d_r <= push;
      count_r  <= count_nxt;
      if (push_d_r) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_d_r  <= pos;
    last_d_r <= last;
    if (push_d_r) begin
      buf_r[wr_ptr_r] <= entry;
    end
  end

  // master port
  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = {6'd0, buf_r[rd_ptr_r].c2, buf_r[rd_ptr_r].c1, buf_r[rd_ptr_r].pos};
  assign out_tlast  = buf_r[rd_ptr_r].last;

  // the credit check must keep the buffer from overflowing
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) && push_d_r |-> pop)
    else $error("merge buffer overflow");

endmodule
